[sv/assert_macros.svh]
// Assertion macros shared by the basis unit.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled while reset is active.
`define RSHB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is active.
`define RSHB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[sv/rshb_pkg.sv]
// Package of the spherical-harmonic basis unit: payload types, widths,
// CORDIC constants and the Legendre coefficient ROM. Depends on nothing.
package rshb_pkg;

	localparam int unsigned MAX_DEGREE_DEF = 6;
	localparam int unsigned ANGLE_W = 16;
	localparam int unsigned DEG_W = 3;
	localparam int unsigned IDX_W = 6;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned TRIG_W = 18;
	localparam int unsigned COEF_W = 24;
	localparam int unsigned XY_W = 33;
	localparam int unsigned Z_W = 25;
	localparam int unsigned TRIG_RAM_DEPTH = 32;

	localparam logic REG_MAX_DEGREE = 1'b0;
	localparam logic REG_MAX_ORDER = 1'b1;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [TRIG_W-1:0] TRIG_ONE = 18'sd65536;

	typedef struct packed {
		logic [ANGLE_W-1:0] polar_angle;
		logic [ANGLE_W-1:0] azimuth_angle;
		logic final_direction;
	} rshb_in_t;

	typedef struct packed {
		logic [IDX_W-1:0] term_index;
		logic [DEG_W-1:0] degree;
		logic [DEG_W-1:0] order;
		logic sine_part;
		logic signed [VAL_W-1:0] basis_value;
		logic signed [VAL_W-1:0] legendre_value;
		logic last_term;
		logic final_direction_res;
	} rshb_out_t;

	function automatic logic signed [Z_W-1:0] atan_step(input logic [3:0] i);
		logic signed [Z_W-1:0] a;
		unique case (i)
			4'd0: a = 25'sd2097152;
			4'd1: a = 25'sd1238021;
			4'd2: a = 25'sd654136;
			4'd3: a = 25'sd332050;
			4'd4: a = 25'sd166669;
			4'd5: a = 25'sd83416;
			4'd6: a = 25'sd41718;
			4'd7: a = 25'sd20860;
			4'd8: a = 25'sd10430;
			4'd9: a = 25'sd5215;
			4'd10: a = 25'sd2608;
			4'd11: a = 25'sd1304;
			4'd12: a = 25'sd652;
			4'd13: a = 25'sd326;
			4'd14: a = 25'sd163;
			4'd15: a = 25'sd81;
		endcase
		return a;
	endfunction

	// Coefficient of cos^n * sin^m in P_l^m, scaled by 256.
	function automatic logic signed [COEF_W-1:0] coef(input logic [2:0] l,
		input logic [2:0] m, input logic [2:0] n);
		logic signed [COEF_W-1:0] c;
		unique case ({l, m, n})
			9'o000: c = 24'sd256;
			9'o101: c = 24'sd256;
			9'o200: c = -24'sd128;
			9'o202: c = 24'sd384;
			9'o301: c = -24'sd384;
			9'o303: c = 24'sd640;
			9'o400: c = 24'sd96;
			9'o402: c = -24'sd960;
			9'o404: c = 24'sd1120;
			9'o501: c = 24'sd480;
			9'o503: c = -24'sd2240;
			9'o505: c = 24'sd2016;
			9'o600: c = -24'sd80;
			9'o602: c = 24'sd1680;
			9'o604: c = -24'sd5040;
			9'o606: c = 24'sd3696;
			9'o110: c = 24'sd256;
			9'o211: c = 24'sd768;
			9'o310: c = -24'sd384;
			9'o312: c = 24'sd1920;
			9'o411: c = -24'sd1920;
			9'o413: c = 24'sd4480;
			9'o510: c = 24'sd480;
			9'o512: c = -24'sd6720;
			9'o514: c = 24'sd10080;
			9'o611: c = 24'sd3360;
			9'o613: c = -24'sd20160;
			9'o615: c = 24'sd22176;
			9'o220: c = 24'sd768;
			9'o321: c = 24'sd3840;
			9'o420: c = -24'sd1920;
			9'o422: c = 24'sd13440;
			9'o521: c = -24'sd13440;
			9'o523: c = 24'sd40320;
			9'o620: c = 24'sd3360;
			9'o622: c = -24'sd60480;
			9'o624: c = 24'sd110880;
			9'o330: c = 24'sd3840;
			9'o431: c = 24'sd26880;
			9'o530: c = -24'sd13440;
			9'o532: c = 24'sd120960;
			9'o631: c = -24'sd120960;
			9'o633: c = 24'sd443520;
			9'o440: c = 24'sd26880;
			9'o541: c = 24'sd241920;
			9'o640: c = -24'sd120960;
			9'o642: c = 24'sd1330560;
			9'o550: c = 24'sd241920;
			9'o651: c = 24'sd2661120;
			9'o660: c = 24'sd2661120;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

endpackage

[sv/rshb_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read.
// Depends on nothing.
module rshb_ram #(
	parameter int unsigned WIDTH = 18,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/rshb_cordic.sv]
// Iterative rotation-mode CORDIC giving sine and cosine of a 16-bit angle,
// one micro-rotation per cycle. Depends on rshb_pkg.
module rshb_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [rshb_pkg::ANGLE_W-1:0]        angle,
	output logic                                done,
	output logic signed [rshb_pkg::TRIG_W-1:0]  sin_val,
	output logic signed [rshb_pkg::TRIG_W-1:0]  cos_val
);

	logic signed [rshb_pkg::XY_W-1:0] x_q, y_q, dx, dy, xr, yr;
	logic signed [rshb_pkg::Z_W-1:0] z_q;
	logic [1:0] quad_q;
	logic [3:0] i_q;
	logic run_q, done_q;
	logic signed [rshb_pkg::TRIG_W-1:0] c, s;

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= run_q && (i_q == 4'd15);
			if (start) begin
				run_q <= 1'b1;
				i_q <= '0;
			end else if (run_q) begin
				i_q <= i_q + 4'd1;
				if (i_q == 4'd15) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= rshb_pkg::CORDIC_GAIN;
			y_q <= '0;
			z_q <= $signed({3'b000, angle[13:0], 8'h00});
			quad_q <= angle[15:14];
		end else if (run_q) begin
			if (!z_q[rshb_pkg::Z_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - rshb_pkg::atan_step(i_q);
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + rshb_pkg::atan_step(i_q);
			end
		end
	end

	assign xr = (x_q + 33'sd8192) >>> 14;
	assign yr = (y_q + 33'sd8192) >>> 14;

	always_comb begin
		if (xr > 33'sd65536) begin
			c = rshb_pkg::TRIG_ONE;
		end else if (xr < -33'sd65536) begin
			c = -rshb_pkg::TRIG_ONE;
		end else begin
			c = xr[rshb_pkg::TRIG_W-1:0];
		end
		if (yr > 33'sd65536) begin
			s = rshb_pkg::TRIG_ONE;
		end else if (yr < -33'sd65536) begin
			s = -rshb_pkg::TRIG_ONE;
		end else begin
			s = yr[rshb_pkg::TRIG_W-1:0];
		end
		unique case (quad_q)
			2'd0: begin
				cos_val = c;
				sin_val = s;
			end
			2'd1: begin
				cos_val = -s;
				sin_val = c;
			end
			2'd2: begin
				cos_val = -c;
				sin_val = -s;
			end
			2'd3: begin
				cos_val = s;
				sin_val = -c;
			end
		endcase
	end

	assign done = done_q;

endmodule

[sv/real_spherical_harmonic_basis_unit.sv]
// Top level of the real spherical-harmonic basis unit: sequencer, trig table
// RAM, CORDIC and the Legendre multiply-accumulate. Depends on rshb_pkg,
// rshb_ram, rshb_cordic and assert_macros.svh.
//
// Channel    Signals                          Transfer
// request    start, busy, request             start high while busy low
// result     result_strobe, result            every cycle result_strobe is high
// config     cfg_we, cfg_index, cfg_data      every cycle cfg_we is high
//
// A direction first runs one CORDIC evaluation for theta and one per order up
// to MAX_DEGREE, then forms the powers of cos and sin of theta, then for each
// (l,m) runs its Legendre products before the terms of that (l,m) are emitted.
// The single RAM read port and the CORDIC unit set the pace.
// One direction is buffered while another is being worked on. Results cannot
// be stalled. Reset clears the sequencer and restores both registers to 6.
module real_spherical_harmonic_basis_unit #(
	parameter int unsigned MAX_DEGREE = rshb_pkg::MAX_DEGREE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  rshb_pkg::rshb_in_t   request,
	output logic                 result_strobe,
	output rshb_pkg::rshb_out_t  result,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [2:0]           cfg_data
);

	`include "assert_macros.svh"

	localparam int unsigned AW = $clog2(rshb_pkg::TRIG_RAM_DEPTH);
	localparam logic [2:0] MAXD = 3'(MAX_DEGREE);
	localparam logic [1:0] K_TC = 2'd0;
	localparam logic [1:0] K_TS = 2'd1;
	localparam logic [1:0] K_FC = 2'd2;
	localparam logic [1:0] K_FS = 2'd3;

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_CSTART = 13'b0000000000010,
		ST_CWAIT  = 13'b0000000000100,
		ST_CWR2   = 13'b0000000001000,
		ST_POW_C  = 13'b0000000010000,
		ST_POW_S  = 13'b0000000100000,
		ST_T_RS   = 13'b0000001000000,
		ST_T_WS   = 13'b0000010000000,
		ST_T_RN   = 13'b0000100000000,
		ST_T_M1   = 13'b0001000000000,
		ST_T_M2   = 13'b0010000000000,
		ST_T_P    = 13'b0100000000000,
		ST_T_TRIG = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic [2:0] max_degree_q, max_order_q, l_eff, m_eff;
	rshb_pkg::rshb_in_t hold_q;
	logic hold_full_q;

	logic [15:0] theta_q, phi_q, ang_q;
	logic fin_q, sp_q;
	logic [2:0] lmax_q, mmax_q, j_q, l_q, m_q, n_q, lm_diff, wr_idx;
	logic [5:0] cnt_q;

	logic signed [17:0] tc1_q, ts1_q, pc_q, ps_q, sin_q, ts_m_q, rd_val;
	logic signed [35:0] pc_prod, ps_prod;
	logic signed [17:0] pc_next, ps_next;
	logic signed [41:0] p1_s1;
	logic signed [59:0] acc_q, acc_rnd;
	logic signed [31:0] p_q;
	logic signed [49:0] b_prod, b_rnd;

	logic wr_en;
	logic [AW-1:0] wr_addr, rd_addr, rd_addr_q;
	logic [17:0] wr_data, rd_data;

	logic cordic_start, cordic_done;
	logic [15:0] cordic_angle;
	logic signed [17:0] cordic_sin, cordic_cos;

	rshb_pkg::rshb_out_t result_q;
	logic strobe_q;

	rshb_ram #(
		.WIDTH(rshb_pkg::TRIG_W),
		.DEPTH(rshb_pkg::TRIG_RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	rshb_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cordic_start),
		.angle   (cordic_angle),
		.done    (cordic_done),
		.sin_val (cordic_sin),
		.cos_val (cordic_cos)
	);

	assign l_eff = (max_degree_q > MAXD) ? MAXD : max_degree_q;
	assign m_eff = (max_order_q > l_eff) ? l_eff : max_order_q;
	assign lm_diff = l_q - m_q;
	assign wr_idx = (j_q == 3'd0) ? 3'd1 : j_q;

	assign cordic_start = (state_q == ST_CSTART);
	assign cordic_angle = (j_q == 3'd0) ? theta_q : ang_q;

	assign pc_prod = tc1_q * pc_q;
	assign ps_prod = ts1_q * ps_q;
	assign pc_next = 18'((pc_prod + 36'sd32768) >>> 16);
	assign ps_next = 18'((ps_prod + 36'sd32768) >>> 16);

	assign acc_rnd = (acc_q + 60'sd8388608) >>> 24;
	assign b_prod = rd_val * p_q;
	assign b_rnd = (b_prod + 50'sd32768) >>> 16;

	always_comb begin
		if (rd_addr_q[2:0] == 3'd0) begin
			rd_val = (rd_addr_q[4:3] == K_FS) ? 18'sd0 : rshb_pkg::TRIG_ONE;
		end else begin
			rd_val = $signed(rd_data);
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		rd_addr = '0;
		unique case (state_q)
			ST_CWAIT: begin
				wr_en = cordic_done;
				wr_addr = {((j_q == 3'd0) ? K_TC : K_FC), wr_idx};
				wr_data = cordic_cos;
			end
			ST_CWR2: begin
				wr_en = 1'b1;
				wr_addr = {((j_q == 3'd0) ? K_TS : K_FS), wr_idx};
				wr_data = sin_q;
			end
			ST_POW_C: begin
				wr_en = 1'b1;
				wr_addr = {K_TC, j_q};
				wr_data = pc_next;
			end
			ST_POW_S: begin
				wr_en = 1'b1;
				wr_addr = {K_TS, j_q};
				wr_data = ps_next;
			end
			ST_T_RS: rd_addr = {K_TS, m_q};
			ST_T_WS, ST_T_RN: rd_addr = {K_TC, n_q};
			ST_T_P: rd_addr = {K_FC, m_q};
			ST_T_TRIG: rd_addr = {K_FS, m_q};
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rd_addr_q <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_degree_q <= 3'd6;
			max_order_q <= 3'd6;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rshb_pkg::REG_MAX_DEGREE: max_degree_q <= cfg_data;
				rshb_pkg::REG_MAX_ORDER: max_order_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_full_q <= 1'b0;
		end else if (start && !hold_full_q) begin
			hold_full_q <= 1'b1;
		end else if (state_q == ST_IDLE) begin
			hold_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !hold_full_q) begin
			hold_q <= request;
		end
	end

	assign busy = hold_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_T_TRIG);
			unique case (state_q)
				ST_IDLE: begin
					if (hold_full_q) begin
						state_q <= ST_CSTART;
					end
				end
				ST_CSTART: state_q <= ST_CWAIT;
				ST_CWAIT: begin
					if (cordic_done) begin
						state_q <= ST_CWR2;
					end
				end
				ST_CWR2: begin
					if (j_q != MAXD) begin
						state_q <= ST_CSTART;
					end else if (MAXD >= 3'd2) begin
						state_q <= ST_POW_C;
					end else begin
						state_q <= ST_T_RS;
					end
				end
				ST_POW_C: state_q <= ST_POW_S;
				ST_POW_S: state_q <= (j_q == MAXD) ? ST_T_RS : ST_POW_C;
				ST_T_RS: state_q <= ST_T_WS;
				ST_T_WS, ST_T_RN: state_q <= ST_T_M1;
				ST_T_M1: state_q <= ST_T_M2;
				ST_T_M2: begin
					if (({1'b0, n_q} + 4'd2) <= {1'b0, lm_diff}) begin
						state_q <= ST_T_RN;
					end else begin
						state_q <= ST_T_P;
					end
				end
				ST_T_P: state_q <= ST_T_TRIG;
				ST_T_TRIG: begin
					if (m_q != 3'd0 && !sp_q) begin
						state_q <= ST_T_TRIG;
					end else if (l_q < lmax_q || m_q < mmax_q) begin
						state_q <= ST_T_RS;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				theta_q <= hold_q.polar_angle;
				phi_q <= hold_q.azimuth_angle;
				ang_q <= hold_q.azimuth_angle;
				fin_q <= hold_q.final_direction;
				lmax_q <= l_eff;
				mmax_q <= m_eff;
				j_q <= '0;
			end
			ST_CWAIT: begin
				if (cordic_done) begin
					sin_q <= cordic_sin;
					if (j_q == 3'd0) begin
						tc1_q <= cordic_cos;
						pc_q <= cordic_cos;
						ts1_q <= cordic_sin;
						ps_q <= cordic_sin;
					end
				end
			end
			ST_CWR2: begin
				if (j_q != MAXD) begin
					j_q <= j_q + 3'd1;
					if (j_q != 3'd0) begin
						ang_q <= ang_q + phi_q;
					end
				end else begin
					j_q <= 3'd2;
				end
				m_q <= '0;
				l_q <= '0;
				sp_q <= 1'b0;
				cnt_q <= '0;
			end
			ST_POW_C: pc_q <= pc_next;
			ST_POW_S: begin
				ps_q <= ps_next;
				j_q <= j_q + 3'd1;
			end
			ST_T_RS: begin
				n_q <= {2'b00, lm_diff[0]};
				acc_q <= '0;
			end
			ST_T_WS: ts_m_q <= rd_val;
			ST_T_M1: p1_s1 <= rshb_pkg::coef(l_q, m_q, n_q) * rd_val;
			ST_T_M2: begin
				acc_q <= acc_q + p1_s1 * ts_m_q;
				n_q <= n_q + 3'd2;
			end
			ST_T_P: p_q <= rshb_pkg::sat32(64'(acc_rnd));
			ST_T_TRIG: begin
				result_q.term_index <= cnt_q + 6'd1;
				result_q.degree <= l_q;
				result_q.order <= m_q;
				result_q.sine_part <= sp_q;
				result_q.basis_value <= rshb_pkg::sat32(64'(b_rnd));
				result_q.legendre_value <= p_q;
				result_q.last_term <= (m_q == mmax_q) && (l_q == lmax_q)
					&& (sp_q || m_q == 3'd0);
				result_q.final_direction_res <= fin_q;
				cnt_q <= cnt_q + 6'd1;
				if (m_q != 3'd0 && !sp_q) begin
					sp_q <= 1'b1;
				end else if (l_q < lmax_q) begin
					sp_q <= 1'b0;
					l_q <= l_q + 3'd1;
				end else begin
					sp_q <= 1'b0;
					m_q <= m_q + 3'd1;
					l_q <= m_q + 3'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_strobe = strobe_q;
	assign result = result_q;

	`RSHB_ASSERT_IMP(a_index_nonzero, clk, arst_n, result_strobe,
		result.term_index != 6'd0, "term index zero on a transfer")
	`RSHB_ASSERT_IMP(a_order_le_degree, clk, arst_n, result_strobe,
		result.order <= result.degree, "order above degree")
	`RSHB_ASSERT_NXT(a_gap_after_last, clk, arst_n, result_strobe && result.last_term,
		!result_strobe, "transfer directly after the last term")
	`RSHB_ASSERT_IMP(a_cordic_expected, clk, arst_n, cordic_done,
		state_q == ST_CWAIT, "CORDIC finished outside its wait state")

endmodule
